@@ rtl/core/btmx_pkg.sv @@
// Shared types and constants for the binary trie maximum-XOR block.
`default_nettype none

package btmx_pkg;

  localparam int KEY_W = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/btmx_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface btmx_in_if import btmx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface btmx_out_if import btmx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] xor_result;
  logic             trie_empty;
  logic             insert_refused;

  modport source (output valid, output xor_result, output trie_empty,
                  output insert_refused, input ready);
  modport sink   (input valid, input xor_result, input trie_empty,
                  input insert_refused, output ready);
endinterface

`default_nettype wire

@@ rtl/core/btmx_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module btmx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/binary_trie_max_xor.sv @@
// Binary trie of unsigned keys with insert and maximum-XOR query.
//
// Usage: requests arrive on in_chan (valid/ready). req_type selects insert
// or query; key_value carries the key, bits at or above KEY_BITS ignored.
// Each request gives one result on out_chan (valid/ready), held in an
// output register until taken.
// A request that walks the trie makes one node-memory read (and for an
// insert at most one write) per key bit. A query on an empty trie and a
// refused insert give their result without a walk.
// The block takes one request at a time; in_chan.ready is high only when
// no request is in flight and no result is waiting, so a stalled receiver
// holds the whole block.
// Reset empties the trie by clearing the node fill count; the node memory
// needs no clearing pass, and requests are taken right after reset.
// An insert is refused, and the trie left unchanged, when fewer than
// KEY_BITS nodes remain free.
`default_nettype none

module binary_trie_max_xor import btmx_pkg::*; #(
  parameter int KEY_BITS   = 32,
  parameter int POOL_NODES = 4096
) (
  input wire logic clk,
  input wire logic rst_n,
  btmx_in_if.sink  in_chan,
  btmx_out_if.source out_chan
);

  localparam int LVL_W  = $clog2(KEY_BITS);
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = $clog2(POOL_NODES + 1);
  localparam int ENT_W  = 2 * NODE_W;
  localparam logic [CNT_W-1:0] FREE_LIMIT = CNT_W'(POOL_NODES - KEY_BITS);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  state_t               state_r, state_nxt;
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [KEY_BITS-1:0]  acc_r, acc_nxt;
  logic                 is_query_r, is_query_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [CNT_W-1:0]     next_free_r, next_free_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic [KEY_W-1:0]     res_xor_r, res_xor_nxt;
  logic                 res_empty_r, res_empty_nxt;
  logic                 res_refused_r, res_refused_nxt;

  logic                 in_accept;
  logic                 out_accept;
  logic                 wr_en;
  logic [ENT_W-1:0]     wr_data;
  logic                 rd_en;
  logic [NODE_W-1:0]    rd_addr;
  logic [ENT_W-1:0]     rd_data;
  logic [ENT_W-1:0]     entry;
  logic                 key_bit;
  logic [NODE_W-1:0]    link_same;
  logic [NODE_W-1:0]    link_other;
  logic [NODE_W-1:0]    new_node;
  logic                 alloc;

  btmx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_NODES)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_chan.ready           = (state_r == ST_IDLE);
  assign in_accept               = in_chan.valid && in_chan.ready;
  assign out_chan.valid          = (state_r == ST_DONE);
  assign out_accept              = out_chan.valid && out_chan.ready;
  assign out_chan.xor_result     = res_xor_r;
  assign out_chan.trie_empty     = res_empty_r;
  assign out_chan.insert_refused = res_refused_r;

  assign entry      = fresh_r ? '0 : rd_data;
  assign key_bit    = key_r[level_r];
  assign link_same  = key_bit ? entry[ENT_W-1:NODE_W] : entry[NODE_W-1:0];
  assign link_other = key_bit ? entry[NODE_W-1:0] : entry[ENT_W-1:NODE_W];
  assign new_node   = next_free_r[NODE_W-1:0];
  assign alloc      = !is_query_r && (link_same == '0);
  assign wr_en      = (state_r == ST_WALK) && alloc;
  assign wr_data    = key_bit ? {new_node, entry[NODE_W-1:0]}
                              : {entry[ENT_W-1:NODE_W], new_node};

  always_comb begin
    state_nxt       = state_r;
    level_nxt       = level_r;
    cur_nxt         = cur_r;
    key_nxt         = key_r;
    acc_nxt         = acc_r;
    is_query_nxt    = is_query_r;
    fresh_nxt       = fresh_r;
    next_free_nxt   = next_free_r;
    nonempty_nxt    = nonempty_r;
    res_xor_nxt     = res_xor_r;
    res_empty_nxt   = res_empty_r;
    res_refused_nxt = res_refused_r;
    rd_en           = 1'b0;
    rd_addr         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          key_nxt         = in_chan.key_value[KEY_BITS-1:0];
          is_query_nxt    = (in_chan.req_type == REQ_QUERY);
          level_nxt       = LVL_W'(KEY_BITS - 1);
          cur_nxt         = '0;
          acc_nxt         = '0;
          fresh_nxt       = (next_free_r == CNT_ONE);
          res_xor_nxt     = '0;
          res_empty_nxt   = 1'b0;
          res_refused_nxt = 1'b0;
          if (in_chan.req_type == REQ_QUERY && !nonempty_r) begin
            res_empty_nxt = 1'b1;
            state_nxt     = ST_DONE;
          end else if (in_chan.req_type == REQ_INSERT && next_free_r > FREE_LIMIT) begin
            res_refused_nxt = 1'b1;
            state_nxt       = ST_DONE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (is_query_r) begin
          if (link_other != '0) begin
            acc_nxt[level_r] = 1'b1;
            cur_nxt          = link_other;
          end else begin
            cur_nxt = link_same;
          end
        end else if (alloc) begin
          cur_nxt       = new_node;
          next_free_nxt = next_free_r + CNT_ONE;
          fresh_nxt     = 1'b1;
        end else begin
          cur_nxt = link_same;
        end
        rd_addr = cur_nxt;
        if (level_r == '0) begin
          res_xor_nxt = is_query_r ? KEY_W'(acc_nxt) : '0;
          if (!is_query_r) begin
            nonempty_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          level_nxt = level_r - LVL_W'(1);
        end
      end
      ST_DONE: begin
        if (out_accept) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_free_r <= CNT_ONE;
      nonempty_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      nonempty_r  <= nonempty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r       <= level_nxt;
    cur_r         <= cur_nxt;
    key_r         <= key_nxt;
    acc_r         <= acc_nxt;
    is_query_r    <= is_query_nxt;
    fresh_r       <= fresh_nxt;
    res_xor_r     <= res_xor_nxt;
    res_empty_r   <= res_empty_nxt;
    res_refused_r <= res_refused_nxt;
  end

endmodule

`default_nettype wire
